// ===== rtl/core/stq_pkg.sv =====
// Shared constants and the command and status types of the sorted timer queue.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package stq_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int RESULT_LIMIT   = 16;
    localparam int FIRE_W         = $clog2(RESULT_LIMIT);

    typedef struct packed {
        logic capture;
        logic insert_new;
        logic insert_saved;
        logic pop;
        logic emit;
        logic fired;
        logic dropped;
        logic last;
    } stq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic head_zero;
        logic head_periodic;
    } stq_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/stq_ctrl.sv =====
// Controller of the sorted timer queue: sequences insert, pop and result steps.
// Depends on stq_pkg.
`default_nettype none
module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        mode,
    input  wire stq_status_t status,
    output stq_cmd_t         cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_POP,
        ST_REINS,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [FIRE_W-1:0]   n_reg, n_next;
    logic                fire_reg, fire_next;
    logic                drop_reg, drop_next;
    logic                more;

    assign busy = (state_reg != ST_IDLE);
    // another zero head may fire while the per-item result limit allows it
    assign more = !status.empty && status.head_zero && (n_reg < FIRE_W'(RESULT_LIMIT - 1));

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        fire_next  = fire_reg;
        drop_next  = drop_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    n_next      = '0;
                    drop_next   = 1'b0;
                    fire_next   = 1'b0;
                    if (!mode)
                        state_next = ST_INS;
                    else if (status.empty)
                        state_next = ST_EMIT;
                    else
                    begin
                        fire_next  = 1'b1;
                        state_next = ST_POP;
                    end
                end
            end
            ST_INS:
            begin
                cmd.insert_new = !status.full;
                drop_next      = status.full;
                state_next     = ST_EMIT;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = status.head_periodic ? ST_REINS : ST_EMIT;
            end
            ST_REINS:
            begin
                cmd.insert_saved = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit    = 1'b1;
                cmd.fired   = fire_reg;
                cmd.dropped = drop_reg;
                cmd.last    = !(fire_reg && more);
                if (fire_reg && more)
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_POP;
                end
                else
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            fire_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            fire_reg  <= fire_next;
            drop_reg  <= drop_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/stq_datapath.sv =====
// Datapath of the sorted timer queue: sorted entry registers and result registers.
// Depends on stq_pkg.
`default_nettype none
module stq_datapath
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire stq_cmd_t    cmd,
    input  wire logic [3:0]  handler_id,
    input  wire logic [31:0] period,
    input  wire logic        periodic,
    output stq_status_t      status,
    output logic             done,
    output logic             fired,
    output logic [3:0]       fired_handler,
    output logic [31:0]      next_delay,
    output logic             queue_empty,
    output logic             start_dropped,
    output logic             last
);

    localparam int CW = $clog2(MAX_TIMERS + 1);

    logic [31:0]   rem_reg [MAX_TIMERS];
    logic [31:0]   per_reg [MAX_TIMERS];
    logic          perd_reg[MAX_TIMERS];
    logic [3:0]    h_reg   [MAX_TIMERS];
    logic [CW-1:0] count_reg;

    logic [3:0]    in_h_reg;
    logic [31:0]   in_p_reg;
    logic          in_perd_reg;
    logic [3:0]    sav_h_reg;
    logic [31:0]   sav_p_reg;

    logic [31:0]   ins_p;
    logic [3:0]    ins_h;
    logic          ins_perd;
    logic          lt[MAX_TIMERS];

    assign ins_p    = cmd.insert_new ? in_p_reg : sav_p_reg;
    assign ins_h    = cmd.insert_new ? in_h_reg : sav_h_reg;
    assign ins_perd = cmd.insert_new ? in_perd_reg : 1'b1;

    // entries strictly below the new time stay put; the sorted order makes them a prefix
    always_comb
    begin
        for (int i = 0; i < MAX_TIMERS; i++)
            lt[i] = (CW'(i) < count_reg) && (rem_reg[i] < ins_p);
    end

    assign status.empty         = (count_reg == '0);
    assign status.full          = (count_reg == CW'(MAX_TIMERS));
    assign status.head_zero     = (rem_reg[0] == 32'd0);
    assign status.head_periodic = perd_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_h_reg    <= handler_id;
            in_p_reg    <= (period == 32'd0) ? 32'd1 : period;
            in_perd_reg <= periodic;
        end
        if (cmd.pop)
        begin
            sav_h_reg <= h_reg[0];
            sav_p_reg <= per_reg[0];
            for (int i = 0; i < MAX_TIMERS - 1; i++)
            begin
                rem_reg[i]  <= rem_reg[i+1] - rem_reg[0];
                per_reg[i]  <= per_reg[i+1];
                perd_reg[i] <= perd_reg[i+1];
                h_reg[i]    <= h_reg[i+1];
            end
        end
        else if (cmd.insert_new || cmd.insert_saved)
        begin
            for (int i = 0; i < MAX_TIMERS; i++)
            begin
                if (!lt[i])
                begin
                    if (i == 0 || lt[(i == 0) ? 0 : i-1])
                    begin
                        rem_reg[i]  <= ins_p;
                        per_reg[i]  <= ins_p;
                        perd_reg[i] <= ins_perd;
                        h_reg[i]    <= ins_h;
                    end
                    else
                    begin
                        rem_reg[i]  <= rem_reg[(i == 0) ? 0 : i-1];
                        per_reg[i]  <= per_reg[(i == 0) ? 0 : i-1];
                        perd_reg[i] <= perd_reg[(i == 0) ? 0 : i-1];
                        h_reg[i]    <= h_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
        if (cmd.emit)
        begin
            fired         <= cmd.fired;
            fired_handler <= cmd.fired ? sav_h_reg : 4'd0;
            next_delay    <= status.empty ? 32'd0 : rem_reg[0];
            queue_empty   <= status.empty;
            start_dropped <= cmd.dropped;
            last          <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= cmd.emit;
            if (cmd.pop)
                count_reg <= count_reg - 1'b1;
            else if (cmd.insert_new || cmd.insert_saved)
                count_reg <= count_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: controller plus datapath.
// Depends on stq_pkg, stq_ctrl and stq_datapath.
//
//  channel   handshake        payload
//  item in   start, busy      mode, handler_id, period, periodic
//  result    done (1 cycle)   fired, fired_handler, next_delay, queue_empty,
//                             start_dropped, last
//
// A start item goes through its capture, insert and result steps before its result
// strobe. An expiry item pops the head, reinserts it when the timer is periodic
// (pop, reinsert, result), then repeats this for each further firing, up to
// sixteen firings; an ignored expiry goes straight to its result.
// The sorted entry registers allow one insert or one pop per cycle.
// Reset clears the entry count and the controller; the entries stay undefined.
// Results cannot be stalled: each is shown for exactly one cycle on done.
`default_nettype none
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [3:0]  handler_id,
    input  wire logic [31:0] period,
    input  wire logic        periodic,
    output logic             done,
    output logic             fired,
    output logic [3:0]       fired_handler,
    output logic [31:0]      next_delay,
    output logic             queue_empty,
    output logic             start_dropped,
    output logic             last
);

    stq_cmd_t    cmd;
    stq_status_t status;

    // sequence the steps of each item
    stq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // hold the sorted entries and register each result
    stq_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .handler_id    (handler_id),
        .period        (period),
        .periodic      (periodic),
        .status        (status),
        .done          (done),
        .fired         (fired),
        .fired_handler (fired_handler),
        .next_delay    (next_delay),
        .queue_empty   (queue_empty),
        .start_dropped (start_dropped),
        .last          (last)
    );

`ifndef NO_ASSERTIONS
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy) else $error("non-final result without further work");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");
    a_empty_delay: assert property (@(posedge clk) disable iff (!rst_n)
        done && queue_empty |-> next_delay == 32'd0) else $error("empty queue with delay");
    a_drop_final: assert property (@(posedge clk) disable iff (!rst_n)
        done && start_dropped |-> !fired && last) else $error("dropped start misreported");
`endif

endmodule
`default_nettype wire
